/* sv/rrtt_pkg.sv */
package rrtt_pkg;

  // Table geometry
  localparam int SLOT_COUNT = 16;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // Field widths
  localparam int KIND_W  = 2;
  localparam int WORD_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int LIVE_W  = 5;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 80;

  // Initial stack frame: align down to 16 bytes, then reserve 15 words
  localparam logic [WORD_W-1:0] SP_ALIGN_MASK = 32'hFFFF_FFF0;
  localparam logic [WORD_W-1:0] FRAME_BYTES   = 32'd60;
  localparam logic [WORD_W-1:0] FIRST_ID      = 32'd1;

  // Event kinds
  typedef enum logic [KIND_W-1:0] {
    K_CREATE = 2'd0,
    K_SWITCH = 2'd1,
    K_EXIT   = 2'd2,
    K_NONE   = 2'd3
  } kind_t;

  // Slot states
  typedef enum logic [1:0] {
    SS_UNUSED  = 2'd0,
    SS_READY   = 2'd1,
    SS_RUNNING = 2'd2,
    SS_DEAD    = 2'd3
  } slot_st_t;

  // Result status codes
  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FAIL = 1'b1;

endpackage

/* sv/round_robin_task_table.sv */
// Round-robin task slot table. Each input transfer is one event (create, switch tick or
// exit, in in_tuser) and gives exactly one result transfer with status, new task id,
// stack pointer, running slot and live count. A single slot-state comparator walks the
// table one slot per cycle, so the cost of an event is set by how far the scan runs:
// create and switch scan the table (a switch with a running task first saves its stack
// pointer), while exit, unknown kinds and a create with a zero entry address skip the
// scan. in_tready is low while an event is in work; the result sits in an output
// register, so the next event is taken while the previous result waits, and it
// finishes only once that register is free.
module round_robin_task_table
  import rrtt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tuser: kind[1:0]
  // in_tdata: entry_address[31:0], stack_top[63:32], current_sp[95:64]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [KIND_W-1:0]      in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tuser: status[0]
  // out_tdata: task_id[31:0], stack_pointer[63:32], running_slot[67:64],
  //            running_valid[68], live_count[73:69], zero fill[79:74]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic                   out_tuser,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SAVE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  slot_st_t                slot_st_r [SLOT_COUNT];
  slot_st_t                slot_st_nxt [SLOT_COUNT];
  logic [IDX_W-1:0]        cur_r, cur_nxt;
  logic                    cur_vld_r, cur_vld_nxt;
  logic [WORD_W-1:0]       next_id_r, next_id_nxt;
  logic [CNT_W-1:0]        live_r, live_nxt;

  // Latched event
  kind_t                   kind_r, kind_nxt;
  logic [WORD_W-1:0]       top_r, top_nxt;
  logic [WORD_W-1:0]       sp_r, sp_nxt;

  // Scan control
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  slot_st_t                tgt_r, tgt_nxt;

  // Pending result
  logic                    res_st_r, res_st_nxt;
  logic [WORD_W-1:0]       res_id_r, res_id_nxt;
  logic [WORD_W-1:0]       res_sp_r, res_sp_nxt;
  logic                    use_rd_r, use_rd_nxt;

  // Output register
  logic                    out_vld_r, out_vld_nxt;
  logic                    out_st_r, out_st_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;

  // Saved stack pointer memory
  logic [WORD_W-1:0]       stack_mem [SLOT_COUNT];
  logic [WORD_W-1:0]       rd_data_r;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [WORD_W-1:0]       mem_wdata;

  logic [WORD_W-1:0]       init_sp;
  logic [IDX_W-1:0]        idx_inc;
  logic [IDX_W-1:0]        cur_inc;
  logic                    hit;
  logic [WORD_W-1:0]       fin_sp;

  assign init_sp = (top_r & SP_ALIGN_MASK) - FRAME_BYTES;
  assign idx_inc = (idx_r == IDX_W'(SLOT_COUNT - 1)) ? '0 : idx_r + 1'b1;
  assign cur_inc = (cur_r == IDX_W'(SLOT_COUNT - 1)) ? '0 : cur_r + 1'b1;
  assign hit     = (slot_st_r[idx_r] == tgt_r);
  assign fin_sp  = use_rd_r ? rd_data_r : res_sp_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = out_data_r;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    slot_st_nxt = slot_st_r;
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    next_id_nxt = next_id_r;
    live_nxt    = live_r;
    kind_nxt    = kind_r;
    top_nxt     = top_r;
    sp_nxt      = sp_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    tgt_nxt     = tgt_r;
    res_st_nxt  = res_st_r;
    res_id_nxt  = res_id_r;
    res_sp_nxt  = res_sp_r;
    use_rd_nxt  = use_rd_r;
    out_vld_nxt = out_vld_r & ~out_tready;
    out_st_nxt  = out_st_r;
    out_data_nxt = out_data_r;
    mem_we      = 1'b0;
    mem_waddr   = cur_r;
    mem_wdata   = sp_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt   = kind_t'(in_tuser);
          top_nxt    = in_tdata[63:32];
          sp_nxt     = in_tdata[95:64];
          idx_nxt    = '0;
          cnt_nxt    = '0;
          res_st_nxt = ST_FAIL;
          res_id_nxt = '0;
          res_sp_nxt = '0;
          use_rd_nxt = 1'b0;
          case (kind_t'(in_tuser))
            K_CREATE: begin
              tgt_nxt   = SS_UNUSED;
              state_nxt = (in_tdata[31:0] == '0) ? S_FINISH : S_SCAN;
            end
            K_SWITCH: begin
              tgt_nxt   = SS_READY;
              state_nxt = cur_vld_r ? S_SAVE : S_SCAN;
            end
            K_EXIT: begin
              if (cur_vld_r && slot_st_r[cur_r] != SS_DEAD) begin
                slot_st_nxt[cur_r] = SS_DEAD;
                if (live_r != '0) live_nxt = live_r - 1'b1;
                res_st_nxt = ST_DONE;
              end
              state_nxt = S_FINISH;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end

      // store the interrupted pointer, requeue the running slot
      S_SAVE: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = sp_r;
        if (slot_st_r[cur_r] == SS_RUNNING) slot_st_nxt[cur_r] = SS_READY;
        idx_nxt   = cur_inc;
        state_nxt = S_SCAN;
      end

      // one slot per cycle
      S_SCAN: begin
        if (hit) begin
          res_st_nxt = ST_DONE;
          state_nxt  = S_FINISH;
          if (kind_r == K_CREATE) begin
            mem_we    = 1'b1;
            mem_waddr = idx_r;
            mem_wdata = init_sp;
            slot_st_nxt[idx_r] = SS_READY;
            res_id_nxt  = next_id_r;
            res_sp_nxt  = init_sp;
            next_id_nxt = next_id_r + 1'b1;
            live_nxt    = live_r + 1'b1;
          end else begin
            slot_st_nxt[idx_r] = SS_RUNNING;
            cur_nxt     = idx_r;
            cur_vld_nxt = 1'b1;
            use_rd_nxt  = 1'b1;
          end
        end else if (cnt_r == CNT_W'(SLOT_COUNT - 1)) begin
          res_sp_nxt = (kind_r == K_CREATE) ? '0 : sp_r;
          state_nxt  = S_FINISH;
        end else begin
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_st_nxt   = res_st_r;
          out_data_nxt = {6'd0, LIVE_W'(live_r), cur_vld_r,
                          cur_vld_r ? SLOT_W'(cur_r) : SLOT_W'(0),
                          fin_sp, res_id_r};
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cur_r     <= '0;
      cur_vld_r <= 1'b0;
      next_id_r <= FIRST_ID;
      live_r    <= '0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) slot_st_r[i] <= SS_UNUSED;
    end else begin
      state_r   <= state_nxt;
      cur_r     <= cur_nxt;
      cur_vld_r <= cur_vld_nxt;
      next_id_r <= next_id_nxt;
      live_r    <= live_nxt;
      out_vld_r <= out_vld_nxt;
      slot_st_r <= slot_st_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    top_r      <= top_nxt;
    sp_r       <= sp_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    tgt_r      <= tgt_nxt;
    res_st_r   <= res_st_nxt;
    res_id_r   <= res_id_nxt;
    res_sp_r   <= res_sp_nxt;
    use_rd_r   <= use_rd_nxt;
    out_st_r   <= out_st_nxt;
    out_data_r <= out_data_nxt;
  end

  // Stack memory: one write port, one registered read at the scan index
  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= stack_mem[idx_r];
  end

endmodule

/* sv/rrtt_checker.sv */
module rrtt_checker
  import rrtt_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic                   out_tuser,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one event in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an event is in work");

  // a failed event never hands out an id
  a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FAIL |-> out_tdata[31:0] == 32'd0)
    else $error("failed event carries a task id");

  // no running task means slot zero
  a_slot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[68] |-> out_tdata[67:64] == 4'd0)
    else $error("running slot set without a running task");

  // live count bounded by the table size
  a_live_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[73:69] <= 5'(SLOT_COUNT))
    else $error("live count exceeds table size");

endmodule

bind round_robin_task_table rrtt_checker u_rrtt_checker (.*);

/* tb/tb_round_robin_task_table.sv */
`timescale 1ns / 1ps

module tb_round_robin_task_table;
  import rrtt_pkg::*;

  localparam int RANDOM_EVENTS = 1630;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 40;

  // One expected result, fields as they leave the block
  typedef struct packed {
    logic              status;
    logic [WORD_W-1:0] task_id;
    logic [WORD_W-1:0] stack_pointer;
    logic [SLOT_W-1:0] running_slot;
    logic              running_valid;
    logic [LIVE_W-1:0] live_count;
  } task_result_t;

  // Slot table predictor plus the queue of results still owed by the block
  class task_table_scoreboard;
    slot_st_t          slot_st [SLOT_COUNT];
    logic [WORD_W-1:0] resume_sp [SLOT_COUNT];
    int unsigned       cur_slot;
    bit                cur_valid;
    logic [WORD_W-1:0] next_task_id;
    int unsigned       live;
    task_result_t      pending[$];
    int unsigned       mismatches;
    int unsigned       results_seen;
    int unsigned       n_created, n_refused, n_switched, n_idle_switch, n_exited, n_ignored;

    function new();
      foreach (slot_st[i]) begin
        slot_st[i]   = SS_UNUSED;
        resume_sp[i] = '0;
      end
      cur_slot     = 0;
      cur_valid    = 0;
      next_task_id = FIRST_ID;
      live         = 0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
    endtask

    // Apply one accepted event to the table and queue the result it owes
    function void note_event(kind_t kind, logic [WORD_W-1:0] entry,
                             logic [WORD_W-1:0] top, logic [WORD_W-1:0] sp);
      task_result_t r;
      bit           found;
      int unsigned  n;
      r     = '0;
      r.status = ST_FAIL;
      found = 0;
      case (kind)
        K_CREATE: begin
          if (entry != '0) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (!found && slot_st[i] == SS_UNUSED) begin
                found        = 1;
                slot_st[i]   = SS_READY;
                resume_sp[i] = (top & SP_ALIGN_MASK) - FRAME_BYTES;
                r.status        = ST_DONE;
                r.task_id       = next_task_id;
                r.stack_pointer = resume_sp[i];
                next_task_id++;
                live++;
              end
            end
          end
          if (found) n_created++;
          else n_refused++;
        end
        K_SWITCH: begin
          r.stack_pointer = sp;
          if (!cur_valid) begin
            // nothing running: lowest ready slot starts
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (!found && slot_st[i] == SS_READY) begin
                found      = 1;
                cur_slot   = i;
                cur_valid  = 1;
                slot_st[i] = SS_RUNNING;
              end
            end
          end else begin
            // save sp, then scan from the next slot with wrap, self included last
            resume_sp[cur_slot] = sp;
            if (slot_st[cur_slot] == SS_RUNNING) slot_st[cur_slot] = SS_READY;
            n = cur_slot;
            for (int i = 0; i < SLOT_COUNT; i++) begin
              n = (n + 1 >= SLOT_COUNT) ? 0 : n + 1;
              if (!found && slot_st[n] == SS_READY) begin
                found      = 1;
                cur_slot   = n;
                slot_st[n] = SS_RUNNING;
              end
            end
          end
          if (found) begin
            r.status        = ST_DONE;
            r.stack_pointer = resume_sp[cur_slot];
            n_switched++;
          end else begin
            n_idle_switch++;
          end
        end
        K_EXIT: begin
          // exit with nothing running or on a dead slot is ignored
          if (cur_valid && slot_st[cur_slot] != SS_DEAD) begin
            slot_st[cur_slot] = SS_DEAD;
            if (live > 0) live--;
            r.status = ST_DONE;
            n_exited++;
          end else begin
            n_ignored++;
          end
        end
        default: n_ignored++;
      endcase
      r.running_slot  = cur_valid ? cur_slot[SLOT_W-1:0] : '0;
      r.running_valid = cur_valid;
      r.live_count    = live[LIVE_W-1:0];
      pending.push_back(r);
    endfunction

    // Compare one result transfer with the oldest expectation
    task check_result(logic status, logic [OUT_TDATA_W-1:0] data);
      task_result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = pending.pop_front();
        if (status !== e.status)
          report_mismatch($sformatf("status %b, expected %b", status, e.status));
        if (data[31:0] !== e.task_id)
          report_mismatch($sformatf("task_id %h, expected %h", data[31:0], e.task_id));
        if (data[63:32] !== e.stack_pointer)
          report_mismatch($sformatf("stack_pointer %h, expected %h",
                                    data[63:32], e.stack_pointer));
        if (data[67:64] !== e.running_slot)
          report_mismatch($sformatf("running_slot %0d, expected %0d",
                                    data[67:64], e.running_slot));
        if (data[68] !== e.running_valid)
          report_mismatch($sformatf("running_valid %b, expected %b",
                                    data[68], e.running_valid));
        if (data[73:69] !== e.live_count)
          report_mismatch($sformatf("live_count %0d, expected %0d",
                                    data[73:69], e.live_count));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [KIND_W-1:0]      in_tuser = '0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;

  task_table_scoreboard sb = new();
  int src_calm  = 0;
  int sink_calm = 0;

  round_robin_task_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // Idle cycles before the next transfer; now and then a run with no gaps
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // Drive one event; called and returns at a falling edge
  task automatic send_event(kind_t kind, logic [WORD_W-1:0] entry,
                            logic [WORD_W-1:0] top, logic [WORD_W-1:0] sp);
    int gap;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {sp, top, entry};
    do @(posedge clk); while (!in_tready);
    sb.note_event(kind, entry, top, sp);
    @(negedge clk);
  endtask

  // Result side: random stalls on out_tready
  initial begin : result_sink
    int gap;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap(sink_calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tuser, out_tdata);
      @(negedge clk);
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    kind_t             kind;
    logic [WORD_W-1:0] entry, top, sp;
    int                pick;
    int                waited;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes of the fields, create/switch/exit paths
    send_event(K_NONE,   '1, '1, '1);
    send_event(K_EXIT,   '1, '1, '1);
    send_event(K_SWITCH, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF);
    send_event(K_CREATE, 32'h0, 32'h0000_1000, 32'h0);
    send_event(K_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_event(K_CREATE, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF);
    send_event(K_CREATE, 32'h8000_0000, 32'h0000_003F, 32'h0);
    send_event(K_SWITCH, 32'h0, 32'h0, 32'h0);
    send_event(K_SWITCH, 32'h0, 32'h0, 32'hAAAA_AAAA);
    send_event(K_SWITCH, 32'h0, 32'h0, 32'h5555_5555);
    send_event(K_SWITCH, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_event(K_EXIT,   32'h0, 32'h0, 32'h0);
    send_event(K_EXIT,   32'h0, 32'h0, 32'h0);
    send_event(K_NONE,   32'h0, 32'h0, 32'h0);
    send_event(K_SWITCH, 32'h0, 32'h0, 32'h0BAD_F00D);
    send_event(K_CREATE, 32'h0000_4000, 32'h2000_0010, 32'h0);
    send_event(K_SWITCH, 32'h0, 32'h0, 32'h1111_1110);
    send_event(K_EXIT,   32'h0, 32'h0, 32'h0);
    send_event(K_SWITCH, 32'h0, 32'h0, 32'h2222_2220);
    send_event(K_EXIT,   32'h0, 32'h0, 32'h0);
    send_event(K_SWITCH, 32'h0, 32'h0, 32'h3333_3330);
    send_event(K_SWITCH, 32'h0, 32'h0, 32'h4444_4440);

    // Random: mostly switch ticks; creates and exits rare so the table
    // fills, runs full for a while and dies out toward the end
    for (int k = 0; k < RANDOM_EVENTS; k++) begin
      pick  = $urandom_range(0, 999);
      entry = $urandom;
      top   = $urandom;
      sp    = $urandom;
      if (pick < 30) begin
        kind = K_CREATE;
        if (pick < 4) entry = '0;
        case ($urandom_range(0, 7))
          0: top = '0;
          1: top = '1;
          2: top = $urandom_range(0, 63);
          default: ;
        endcase
      end else if (pick < 42) begin
        kind = K_EXIT;
      end else if (pick < 70) begin
        kind = K_NONE;
      end else begin
        kind = K_SWITCH;
      end
      send_event(kind, entry, top, sp);
    end
    in_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray result
    waited = 0;
    while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));

    $display("Checked %0d results: %0d tasks created, %0d creates refused, %0d exits",
             sb.results_seen, sb.n_created, sb.n_refused, sb.n_exited);
    $display("  %0d switches handed over, %0d found nothing ready, %0d events ignored",
             sb.n_switched, sb.n_idle_switch, sb.n_ignored);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
